// ----- design/lrm_pkg.sv -----
// Shared types and codes for the lock manager with revoke and retry messages.
// Request and response beat layouts, operation, status, message and state codes.
// No dependencies.
package lrm_pkg;

    // Request beat
    typedef struct packed {
        logic       op;
        logic [7:0] lock_id;
        logic [5:0] client_id;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] send_kind;
        logic [5:0] send_to;
    } t_rsp;

    // Classified request as it sits in the queue between front and back
    typedef struct packed {
        t_req req;
        logic in_range;
    } t_qitem;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_RETRY = 2'd1;
    localparam logic [1:0] RS_FULL  = 2'd2;

    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_REVOKE = 2'd1;
    localparam logic [1:0] MSG_RETRY  = 2'd2;

    // Lock states as stored in the lock table
    localparam logic [1:0] LS_FREE = 2'd0;
    localparam logic [1:0] LS_HELD = 2'd1;
    localparam logic [1:0] LS_WAIT = 2'd2;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LOOK,
        BS_EXEC
    } t_back_st;

endpackage

// ----- design/lrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lrm_front.sv -----
// Front end: accepts request beats, checks the lock range and queues them
// for the back end. Depends on lrm_pkg.
module lrm_front #(
    parameter int LOCK_COUNT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lrm_pkg::t_req i_req,
    output logic          o_q_valid,
    output lrm_pkg::t_qitem o_q_item,
    input  logic          i_q_pop
);
    import lrm_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);

    t_qitem         r_buf [QDEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PW:0]    r_count,  n_count;
    logic           push;
    t_qitem         item;

    assign o_ready   = (r_count != (PW+1)'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_buf[r_rd_ptr];

    always_comb begin
        item.req      = i_req;
        item.in_range = {9'd0, i_req.lock_id} < 17'(LOCK_COUNT);
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + (PW+1)'(push) - (PW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= item;
        end
    end

endmodule

// ----- design/lrm_back.sv -----
// Back end: reads the lock table and the head waiting slot, applies the
// request, writes the lock entry and, on an enqueue, the tail waiting slot,
// then holds the response beat. Depends on lrm_pkg and lrm_ram.
module lrm_back #(
    parameter int LOCK_COUNT  = 256,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  lrm_pkg::t_qitem i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output lrm_pkg::t_rsp   o_rsp
);
    import lrm_pkg::*;

    localparam int TABLE_DEPTH = (LOCK_COUNT < 256) ? LOCK_COUNT : 256;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = CW + 1;
    localparam int SLOT_DEPTH = TABLE_DEPTH * QUEUE_DEPTH;
    localparam int SAW = $clog2(SLOT_DEPTH);

    typedef struct packed {
        logic [1:0]    state;
        logic [5:0]    holder;
        logic [HW-1:0] head;
        logic [CW-1:0] count;
    } t_entry;

    localparam int EW = $bits(t_entry);

    t_back_st          r_state, n_state;
    t_qitem            r_item;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic              r_ent_vld;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [AW-1:0]     pop_addr;
    logic [AW-1:0]     lk;
    logic [EW-1:0]     lock_rdata;
    logic [5:0]        slot_rdata;
    t_entry            cur;
    t_entry            nxt;
    logic [1:0]        st;
    logic [PW-1:0]     tail_sum;
    logic [HW-1:0]     tail;
    logic [PW-1:0]     head_sum;
    logic [HW-1:0]     head_nx;
    logic              full;
    logic              enq;
    t_rsp              rsp;
    logic              slot_re;
    logic              exec_go;
    logic              lock_we;
    logic              slot_we;
    logic [SAW-1:0]    slot_raddr;
    logic [SAW-1:0]    slot_waddr;

    assign pop_addr = i_q_item.req.lock_id[AW-1:0];
    assign lk       = r_item.req.lock_id[AW-1:0];
    assign cur      = r_ent_vld ? t_entry'(lock_rdata) : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (i_q_valid) n_state = BS_LOOK;
            BS_LOOK: n_state = BS_EXEC;
            BS_EXEC: if (exec_go) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_q_pop = 1'b0;
        slot_re = 1'b0;
        exec_go = 1'b0;
        unique case (r_state)
            BS_IDLE: o_q_pop = i_q_valid;
            BS_LOOK: slot_re = 1'b1;
            BS_EXEC: exec_go = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    // Queue arithmetic on the current entry
    always_comb begin
        tail_sum = PW'(cur.head) + PW'(cur.count);
        tail     = (tail_sum >= PW'(QUEUE_DEPTH)) ? HW'(tail_sum - PW'(QUEUE_DEPTH))
                                                  : HW'(tail_sum);
        head_sum = PW'(cur.head) + PW'(1);
        head_nx  = (head_sum >= PW'(QUEUE_DEPTH)) ? HW'(head_sum - PW'(QUEUE_DEPTH))
                                                  : HW'(head_sum);
        full     = (cur.count >= CW'(QUEUE_DEPTH));
    end

    // Apply the request
    always_comb begin
        // fold unreachable encodings back onto real states
        st = cur.state;
        if (st == LS_WAIT && cur.count == '0) begin
            st = LS_HELD;
        end else if (st != LS_FREE && st != LS_HELD && st != LS_WAIT) begin
            st = LS_FREE;
        end
        nxt       = cur;
        nxt.state = st;
        enq       = 1'b0;
        rsp       = '{status: RS_OK, send_kind: MSG_NONE, send_to: 6'd0};
        if (r_item.in_range) begin
            if (r_item.req.op == OP_ACQUIRE) begin
                unique case (st)
                    LS_FREE: begin
                        nxt.state  = LS_HELD;
                        nxt.holder = r_item.req.client_id;
                    end
                    LS_HELD: begin
                        if (!full) begin
                            enq           = 1'b1;
                            nxt.count     = cur.count + CW'(1);
                            nxt.state     = LS_WAIT;
                            rsp.status    = RS_RETRY;
                            rsp.send_kind = MSG_REVOKE;
                            rsp.send_to   = cur.holder;
                        end else begin
                            rsp.status = RS_FULL;
                        end
                    end
                    default: begin
                        if (slot_rdata == r_item.req.client_id) begin
                            // head waiter takes the lock
                            nxt.holder = r_item.req.client_id;
                            nxt.head   = head_nx;
                            nxt.count  = cur.count - CW'(1);
                            if (cur.count == CW'(1)) begin
                                nxt.state = LS_HELD;
                            end else begin
                                rsp.send_kind = MSG_REVOKE;
                                rsp.send_to   = r_item.req.client_id;
                            end
                        end else if (!full) begin
                            enq        = 1'b1;
                            nxt.count  = cur.count + CW'(1);
                            rsp.status = RS_RETRY;
                        end else begin
                            rsp.status = RS_FULL;
                        end
                    end
                endcase
            end else if (st != LS_FREE) begin
                nxt.holder = 6'd0;
                if (st == LS_HELD) begin
                    nxt.state = LS_FREE;
                end else begin
                    rsp.send_kind = MSG_RETRY;
                    rsp.send_to   = slot_rdata;
                end
            end
        end
    end

    assign lock_we    = exec_go && r_item.in_range;
    assign slot_we    = exec_go && r_item.in_range && enq;
    assign slot_raddr = SAW'(lk) * SAW'(QUEUE_DEPTH) + SAW'(cur.head);
    assign slot_waddr = SAW'(lk) * SAW'(QUEUE_DEPTH) + SAW'(tail);

    lrm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_lock_tab (
        .i_clk   (i_clk),
        .i_we    (lock_we),
        .i_waddr (lk),
        .i_wdata (EW'(nxt)),
        .i_re    (o_q_pop),
        .i_raddr (pop_addr),
        .o_rdata (lock_rdata)
    );

    lrm_ram #(
        .WIDTH (6),
        .DEPTH (SLOT_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_item.req.client_id),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (lock_we) begin
                r_valid[lk] <= 1'b1;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item    <= i_q_item;
            r_ent_vld <= r_valid[pop_addr];
        end
        if (exec_go) begin
            r_out <= rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTH
    // a popped request passes through the look state to the update step
    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == BS_LOOK) ##1 (r_state == BS_EXEC))
        else $error("popped request did not reach the update step");

    // an update always leaves a response waiting
    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> r_out_valid)
        else $error("update without a response beat");

    // the waiting count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EXEC && r_item.in_range) |-> (cur.count <= CW'(QUEUE_DEPTH)))
        else $error("waiting count beyond queue depth");

    // no slot is written into a full queue
    a_no_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |-> !full)
        else $error("enqueue into a full waiting queue");
`endif

endmodule

// ----- design/lock_revoke_retry_manager.sv -----
// Lock manager with revoke and retry messages: one response beat per request.
// Depends on lrm_pkg, lrm_front, lrm_back and lrm_ram.
//
// Each request is classified and queued by the front end (four entries), then
// handled by the back end in order: a lock-table read, a read of the head
// waiting slot, and the update that writes the lock entry and, when a client
// is queued, its waiting slot. The back end takes no new request until the
// update of the last one is done; the slot read depends on the lock entry
// read. The response register lets the front end keep accepting while a beat
// waits to be taken. Lock entries carry a valid bit each, so no clearing pass
// follows reset. Requests to a lock at or above LOCK_COUNT answer ok and
// change nothing.
module lock_revoke_retry_manager #(
    parameter int LOCK_COUNT  = 256,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lrm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output lrm_pkg::t_rsp o_rsp
);
    import lrm_pkg::*;

    logic   q_valid;
    logic   q_pop;
    t_qitem q_item;

    lrm_front #(
        .LOCK_COUNT (LOCK_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    lrm_back #(
        .LOCK_COUNT  (LOCK_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

endmodule
